[design/combined_lcg_shuffled_random_top_defines.svh]
`ifndef COMBINED_LCG_SHUFFLED_RANDOM_TOP_DEFINES_SVH
`define COMBINED_LCG_SHUFFLED_RANDOM_TOP_DEFINES_SVH

// Both macros expect clk_i and rst_ni in the scope where they are used.
`define CLSR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("clsr assertion failed");

`define CLSR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("clsr assertion failed");

`endif

[design/clsr_pkg.sv]
`default_nettype none

package clsr_pkg;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_DRAW = 1'b1
  } op_e;

  typedef logic [30:0] gen_word_t;

  typedef struct packed {
    op_e                op;
    logic signed [31:0] seed;
  } req_t;

  typedef struct packed {
    logic      start;
    gen_word_t x1;
    gen_word_t x2;
  } gen_req_t;

  typedef struct packed {
    logic      done;
    gen_word_t y1;
    gen_word_t y2;
  } gen_rsp_t;

  typedef struct packed {
    logic      start;
    gen_word_t value;
  } slot_cmd_t;

  localparam logic [30:0] Mod1       = 31'd2147483563;
  localparam logic [30:0] Mod2       = 31'd2147483399;
  localparam logic [15:0] Mul1       = 16'd40014;
  localparam logic [15:0] Mul2       = 16'd40692;
  // Both moduli are 2**31 minus a small fold constant.
  localparam logic [7:0]  Fold1      = 8'd85;
  localparam logic [7:0]  Fold2      = 8'd249;
  localparam logic [30:0] OutMax     = 31'd2147483562;
  localparam logic [30:0] Seed2Reset = 31'd123456789;

endpackage

`default_nettype wire

[design/combined_lcg_shuffled_random_top.sv]
// Channel   Handshake     Payload
// request   push / full   func_i, seed_value_i
// result    empty / pop   random_value_o
//
// A load is taken in the idle state alone; a draw passes through the request, the step
// unit, the table read and the result write. The slot lookup registers the value and then
// the slot. A draw that finds a non-positive state first runs warm-up steps
// in the two-stage step unit.
// Reset clears the states, the table valid bits and both queues at once; no clearing pass.
// A two-entry request queue keeps taking requests while the back end works, and a result
// waiting on the output stalls the back end only when the next result is ready.
`default_nettype none

`include "combined_lcg_shuffled_random_top_defines.svh"

module combined_lcg_shuffled_random_top #(
  parameter int unsigned TableDepth = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               func_i,
  input  wire logic signed [31:0] seed_value_i,
  output logic                    empty,
  input  wire logic               pop,
  output logic [30:0]             random_value_o
);
  import clsr_pkg::*;

  localparam int unsigned SlotW = $clog2(TableDepth);

  logic             req_vld;
  logic             req_pop;
  req_t             req;
  gen_req_t         gen_req;
  gen_rsp_t         gen_rsp;
  slot_cmd_t        slot_cmd;
  logic             slot_busy;
  logic [SlotW-1:0] slot;
  logic             res_vld;

  clsr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .func_i       (func_i),
    .seed_value_i (seed_value_i),
    .req_vld_o    (req_vld),
    .req_o        (req),
    .req_pop_i    (req_pop)
  );

  clsr_gen u_gen (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (gen_req),
    .rsp_o  (gen_rsp)
  );

  clsr_slot #(
    .TableDepth (TableDepth)
  ) u_slot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (slot_cmd),
    .busy_o (slot_busy),
    .slot_o (slot)
  );

  clsr_back #(
    .TableDepth (TableDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_vld_i   (req_vld),
    .req_i       (req),
    .req_pop_o   (req_pop),
    .gen_req_o   (gen_req),
    .gen_rsp_i   (gen_rsp),
    .slot_cmd_o  (slot_cmd),
    .slot_busy_i (slot_busy),
    .slot_i      (slot),
    .res_vld_o   (res_vld),
    .res_o       (random_value_o),
    .res_pop_i   (pop)
  );

  assign empty = !res_vld;

  `CLSR_ASSERT_IMP(a_res_range, !empty, (random_value_o != 31'd0) && (random_value_o <= OutMax))
  `CLSR_ASSERT_IMP(a_pop_has_req, req_pop, req_vld)
  `CLSR_ASSERT_NXT(a_load_no_result, req_pop && (req.op == OP_LOAD) && empty, empty)

endmodule

`default_nettype wire

[design/clsr_front.sv]
`default_nettype none

module clsr_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  output logic                    full_o,
  input  wire logic               func_i,
  input  wire logic signed [31:0] seed_value_i,
  output logic                    req_vld_o,
  output clsr_pkg::req_t          req_o,
  input  wire logic               req_pop_i
);
  import clsr_pkg::*;

  req_t       ent_q [2];
  req_t       req_d;
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push_ok;
  logic       pop_ok;

  assign full_o    = (cnt_q == 2'd2);
  assign req_vld_o = (cnt_q != 2'd0);
  assign req_o     = ent_q[rd_q];
  assign push_ok   = push_i && !full_o;
  assign pop_ok    = req_pop_i && req_vld_o;

  always_comb begin
    req_d.op   = func_i ? OP_DRAW : OP_LOAD;
    req_d.seed = seed_value_i;
    wr_d       = push_ok ? !wr_q : wr_q;
    rd_d       = pop_ok ? !rd_q : rd_q;
    case ({push_ok, pop_ok})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      ent_q[wr_q] <= req_d;
    end
  end

endmodule

`default_nettype wire

[design/clsr_gen.sv]
`default_nettype none

module clsr_gen (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire clsr_pkg::gen_req_t req_i,
  output clsr_pkg::gen_rsp_t      rsp_o
);
  import clsr_pkg::*;

  logic [46:0] p1_q, p1_d;
  logic [46:0] p2_q, p2_d;
  logic        v1_q;
  logic [31:0] t1, t2;
  gen_word_t   y1_q, y1_d;
  gen_word_t   y2_q, y2_d;
  logic        v2_q;

  // A product a*x is folded as high*fold + low, which stays below twice the modulus.
  always_comb begin
    p1_d = {31'd0, Mul1} * {16'd0, req_i.x1};
    p2_d = {31'd0, Mul2} * {16'd0, req_i.x2};
    t1   = {16'd0, p1_q[46:31]} * {24'd0, Fold1} + {1'b0, p1_q[30:0]};
    t2   = {16'd0, p2_q[46:31]} * {24'd0, Fold2} + {1'b0, p2_q[30:0]};
    y1_d = (t1 >= {1'b0, Mod1}) ? 31'(t1 - {1'b0, Mod1}) : t1[30:0];
    y2_d = (t2 >= {1'b0, Mod2}) ? 31'(t2 - {1'b0, Mod2}) : t2[30:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= req_i.start;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q <= p1_d;
    p2_q <= p2_d;
    y1_q <= y1_d;
    y2_q <= y2_d;
  end

  assign rsp_o.done = v2_q;
  assign rsp_o.y1   = y1_q;
  assign rsp_o.y2   = y2_q;

endmodule

`default_nettype wire

[design/clsr_slot.sv]
`default_nettype none

module clsr_slot #(
  parameter  int unsigned TableDepth = 32,
  localparam int unsigned SlotW      = $clog2(TableDepth)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire clsr_pkg::slot_cmd_t cmd_i,
  output logic                     busy_o,
  output logic [SlotW-1:0]         slot_o
);
  import clsr_pkg::*;

  localparam logic [31:0] SlotDiv = 32'(1 + OutMax / TableDepth);

  logic             busy_q;
  logic [SlotW-1:0] quo_q, quo_d;
  gen_word_t        val_q;

  // The slot is the highest constant slot boundary that the value reaches.
  always_comb begin
    quo_d = quo_q;
    if (busy_q) begin
      quo_d = '0;
      for (int k = 1; k < TableDepth; k++) begin
        if ({1'b0, val_q} >= 32'(k) * SlotDiv) begin
          quo_d = SlotW'(k);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      quo_q  <= '0;
    end else begin
      busy_q <= cmd_i.start;
      quo_q  <= quo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      val_q <= cmd_i.value;
    end
  end

  assign busy_o = busy_q;
  assign slot_o = quo_q;

endmodule

`default_nettype wire

[design/clsr_back.sv]
`default_nettype none

module clsr_back #(
  parameter  int unsigned TableDepth = 32,
  localparam int unsigned SlotW      = $clog2(TableDepth)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               req_vld_i,
  input  wire clsr_pkg::req_t     req_i,
  output logic                    req_pop_o,
  output clsr_pkg::gen_req_t      gen_req_o,
  input  wire clsr_pkg::gen_rsp_t gen_rsp_i,
  output clsr_pkg::slot_cmd_t     slot_cmd_o,
  input  wire logic               slot_busy_i,
  input  wire logic [SlotW-1:0]   slot_i,
  output logic                    res_vld_o,
  output logic [30:0]             res_o,
  input  wire logic               res_pop_i
);
  import clsr_pkg::*;

  localparam int unsigned CntW = $clog2(TableDepth + 8);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WARM,
    ST_STEP,
    ST_READ,
    ST_OUT
  } state_e;

  state_e                  state_q, state_d;
  logic signed [31:0]      main_q, main_d;
  gen_word_t               sec_q, sec_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [SlotW-1:0]        slot_q, slot_d;
  logic [TableDepth-1:0]   vld_q, vld_d;
  logic                    res_vld_q, res_vld_d;
  gen_word_t               res_q, res_d;

  gen_word_t               tbl_q [TableDepth];
  gen_word_t               rd_q;
  logic                    rd_vld_q;
  logic                    rd_en;
  logic                    wr_en;
  logic [SlotW-1:0]        wr_addr;
  gen_word_t               wr_data;

  logic [31:0]             neg_main;
  logic                    main_le0;
  gen_word_t               seed_v;
  gen_word_t               rd_val;
  logic [31:0]             diff;
  gen_word_t               y;

  always_comb begin
    neg_main = 32'd0 - main_q;
    main_le0 = main_q[31] || (main_q == 32'sd0);
    if (main_q == 32'sd0) begin
      seed_v = 31'd1;
    end else if (neg_main[31]) begin
      seed_v = 31'h7FFF_FFFF;
    end else begin
      seed_v = neg_main[30:0];
    end
    rd_val = rd_vld_q ? rd_q : 31'd0;
    diff   = {1'b0, rd_val} - {1'b0, sec_q};
    if (diff[31] || (diff == 32'd0)) begin
      y = diff[30:0] + OutMax;
    end else begin
      y = diff[30:0];
    end
  end

  always_comb begin
    state_d          = state_q;
    main_d           = main_q;
    sec_d            = sec_q;
    cnt_d            = cnt_q;
    slot_d           = slot_q;
    vld_d            = vld_q;
    res_vld_d        = res_vld_q && !res_pop_i;
    res_d            = res_q;
    req_pop_o        = 1'b0;
    gen_req_o.start  = 1'b0;
    gen_req_o.x1     = main_q[30:0];
    gen_req_o.x2     = sec_q;
    slot_cmd_o.start = 1'b0;
    slot_cmd_o.value = y;
    rd_en            = 1'b0;
    wr_en            = 1'b0;
    wr_addr          = slot_q;
    wr_data          = main_q[30:0];

    unique case (state_q)
      ST_IDLE: begin
        if (req_vld_i) begin
          req_pop_o = 1'b1;
          if (req_i.op == OP_LOAD) begin
            main_d = req_i.seed;
          end else if (main_le0) begin
            main_d          = {1'b0, seed_v};
            sec_d           = seed_v;
            cnt_d           = CntW'(TableDepth + 7);
            gen_req_o.start = 1'b1;
            gen_req_o.x1    = seed_v;
            state_d         = ST_WARM;
          end else begin
            gen_req_o.start = 1'b1;
            state_d         = ST_STEP;
          end
        end
      end
      ST_WARM: begin
        if (gen_rsp_i.done) begin
          main_d          = {1'b0, gen_rsp_i.y1};
          gen_req_o.start = 1'b1;
          gen_req_o.x1    = gen_rsp_i.y1;
          if (cnt_q < CntW'(TableDepth)) begin
            wr_en   = 1'b1;
            wr_addr = cnt_q[SlotW-1:0];
            wr_data = gen_rsp_i.y1;
          end
          if (cnt_q == '0) begin
            slot_cmd_o.start = 1'b1;
            slot_cmd_o.value = gen_rsp_i.y1;
            state_d          = ST_STEP;
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
        end
      end
      ST_STEP: begin
        if (gen_rsp_i.done) begin
          main_d  = {1'b0, gen_rsp_i.y1};
          sec_d   = gen_rsp_i.y2;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (!slot_busy_i) begin
          rd_en   = 1'b1;
          slot_d  = slot_i;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!res_vld_q || res_pop_i) begin
          res_vld_d        = 1'b1;
          res_d            = y;
          wr_en            = 1'b1;
          slot_cmd_o.start = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (wr_en) begin
      vld_d[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      main_q    <= '0;
      sec_q     <= Seed2Reset;
      cnt_q     <= '0;
      slot_q    <= '0;
      vld_q     <= '0;
      res_vld_q <= 1'b0;
      res_q     <= '0;
    end else begin
      state_q   <= state_d;
      main_q    <= main_d;
      sec_q     <= sec_d;
      cnt_q     <= cnt_d;
      slot_q    <= slot_d;
      vld_q     <= vld_d;
      res_vld_q <= res_vld_d;
      res_q     <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tbl_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q     <= tbl_q[slot_i];
      rd_vld_q <= vld_q[slot_i];
    end
  end

  assign res_vld_o = res_vld_q;
  assign res_o     = res_q;

endmodule

`default_nettype wire
